[src/mte_pkg.sv]
// Shared types for the 4x4 matrix transform engine.
// Holds the command codes, controller states and the control bundle.
package mte_pkg;

  typedef enum logic [3:0] {
    CMD_WR_CUR = 4'd0,
    CMD_WR_OPD = 4'd1,
    CMD_READ   = 4'd2,
    CMD_XFORM  = 4'd3,
    CMD_MUL    = 4'd4,
    CMD_SCALE  = 4'd5,
    CMD_NEG    = 4'd6,
    CMD_IDENT  = 4'd7,
    CMD_TRANSP = 4'd8,
    CMD_INV    = 4'd9
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_ACC,
    ST_COMMIT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       exec;
    logic       mul_en;
    logic       acc_en;
    logic       first;
    logic       last;
    logic       commit;
    logic       finish;
    cmd_t       cmd;
    logic [3:0] o;
    logic [1:0] k;
  } ctl_t;

endpackage

[src/mte_in_if.sv]
// Command channel of the matrix transform engine.
// Carries valid, ready and one command item; no dependencies.
interface mte_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         command;
  logic [3:0]         elem_index;
  logic signed [31:0] value;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] pz;

  modport source (output valid, command, elem_index, value, px, py, pz, input ready);
  modport sink (input valid, command, elem_index, value, px, py, pz, output ready);
endinterface

[src/mte_out_if.sv]
// Result channel of the matrix transform engine.
// Carries valid, ready and one result item; no dependencies.
interface mte_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] read_value;
  logic               status;

  modport source (output valid, out_x, out_y, out_z, read_value, status, input ready);
  modport sink (input valid, out_x, out_y, out_z, read_value, status, output ready);
endinterface

[src/mte_ctrl.sv]
// Sequencer of the matrix transform engine.
// Steps the MAC loops and the execute-state commands; uses mte_pkg.
module mte_ctrl
  import mte_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [3:0] in_cmd,
  output logic       in_ready,
  input  logic       out_free,
  output ctl_t       ctl
);

  state_t     state, state_next;
  cmd_t       cmd_q, cmd_next;
  logic [3:0] o, o_next;
  logic [1:0] k, k_next;
  logic [1:0] kmax;
  logic [3:0] omax;
  logic       is_mac;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cmd_q <= CMD_WR_CUR;
      o     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      cmd_q <= cmd_next;
      o     <= o_next;
      k     <= k_next;
    end
  end

  always_comb begin
    kmax   = 2'd0;
    omax   = 4'd15;
    is_mac = 1'b0;
    case (cmd_q) inside
      CMD_XFORM, CMD_INV: begin
        kmax   = 2'd2;
        omax   = 4'd2;
        is_mac = 1'b1;
      end
      CMD_MUL: begin
        kmax   = 2'd3;
        is_mac = 1'b1;
      end
      CMD_SCALE: is_mac = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_next  = state;
    cmd_next    = cmd_q;
    o_next      = o;
    k_next      = k;
    in_ready    = 1'b0;
    ctl         = '0;
    ctl.cmd     = cmd_q;
    ctl.o       = o;
    ctl.k       = k;
    ctl.first   = (k == 2'd0);
    ctl.last    = (k == kmax);
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.cmd  = cmd_t'(in_cmd);
        if (in_valid) begin
          ctl.capture = 1'b1;
          cmd_next    = cmd_t'(in_cmd);
          o_next      = '0;
          k_next      = '0;
          case (cmd_t'(in_cmd)) inside
            CMD_XFORM, CMD_MUL, CMD_SCALE, CMD_INV: state_next = ST_MUL;
            default: state_next = ST_EXEC;
          endcase
        end
      end
      ST_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = ST_FIN;
      end
      ST_MUL: begin
        ctl.mul_en = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        ctl.acc_en = 1'b1;
        if (k == kmax) begin
          k_next = '0;
          if (o == omax) begin
            state_next = (cmd_q == CMD_MUL || cmd_q == CMD_INV) ? ST_COMMIT : ST_FIN;
          end else begin
            o_next     = o + 4'd1;
            state_next = ST_MUL;
          end
        end else begin
          k_next     = k + 2'd1;
          state_next = ST_MUL;
        end
      end
      ST_COMMIT: begin
        ctl.commit = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (!is_mac && state == ST_ACC) state_next = ST_FIN;
  end

endmodule

[src/mte_datapath.sv]
// Datapath of the matrix transform engine: matrices, shared MAC, result register.
// Driven by the control bundle from mte_ctrl; uses mte_pkg.
module mte_datapath
  import mte_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  ctl_t               ctl,
  input  logic [3:0]         elem_index,
  input  logic signed [31:0] value,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_free,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] read_value,
  output logic               status
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int XW = ((W > 32) ? W : 32) + 1;
  localparam int SW = 2 * W - F;
  localparam int AW = W + 3;
  localparam int NW = W + 4;

  localparam logic signed [XW-1:0] XMAX = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [NW-1:0] NMAX = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0]  ONE  =
      (F < W - 1) ? (W'(1) << F) : WMAX;

  function automatic logic [W:0] sat_x(input logic signed [XW-1:0] v);
    if (v > XMAX) return {1'b1, WMAX};
    if (v < ~XMAX) return {1'b1, WMIN};
    return {1'b0, v[W-1:0]};
  endfunction

  function automatic logic [W:0] sat_s(input logic signed [SW-1:0] v);
    if (v > SMAX) return {1'b1, WMAX};
    if (v < ~SMAX) return {1'b1, WMIN};
    return {1'b0, v[W-1:0]};
  endfunction

  function automatic logic [W:0] sat_n(input logic signed [NW-1:0] v);
    if (v > NMAX) return {1'b1, WMAX};
    if (v < ~NMAX) return {1'b1, WMIN};
    return {1'b0, v[W-1:0]};
  endfunction

  function automatic logic [31:0] to32(input logic signed [W-1:0] v);
    logic signed [XW-1:0] e;
    e = XW'(v);
    return e[31:0];
  endfunction

  logic signed [W-1:0]   cur [16];
  logic signed [W-1:0]   opm [16];
  logic signed [W-1:0]   tmp [16];
  logic signed [W-1:0]   pvec [3];
  logic signed [W-1:0]   tvec [3];
  logic signed [W-1:0]   res [3];
  logic signed [W-1:0]   sval;
  logic signed [W-1:0]   rd;
  logic [3:0]            idx_q;
  logic                  flag;
  logic signed [2*W-1:0] prod;
  logic signed [AW-1:0]  acc;

  logic [W:0]            sv, sx, sy, sz, fm, fin;
  logic [3:0]            a_addr;
  logic signed [W-1:0]   a_op, b_op, init;
  logic signed [SW-1:0]  sh;
  logic signed [AW-1:0]  sum;
  logic signed [NW-1:0]  fin_in;
  logic [W:0]            negs [16];
  logic                  neg_ov;

  assign sv = sat_x(XW'(value));
  assign sx = sat_x(XW'(px));
  assign sy = sat_x(XW'(py));
  assign sz = sat_x(XW'(pz));

  always_comb begin
    a_addr = idx_q;
    b_op   = sval;
    case (ctl.cmd) inside
      CMD_XFORM: begin
        a_addr = {ctl.k, ctl.o[1:0]};
        b_op   = pvec[ctl.k];
      end
      CMD_MUL: begin
        a_addr = {ctl.k, ctl.o[1:0]};
        b_op   = opm[{ctl.o[3:2], ctl.k}];
      end
      CMD_INV: begin
        a_addr = {ctl.o[1:0], ctl.k};
        b_op   = tvec[ctl.k];
      end
      CMD_SCALE: a_addr = ctl.o;
      default: ;
    endcase
  end

  assign a_op   = cur[a_addr];
  assign init   = (ctl.cmd == CMD_XFORM) ? tvec[ctl.o[1:0]] : '0;
  assign sh     = SW'(prod >>> F);
  assign fm     = sat_s(sh);
  assign sum    = (ctl.first ? AW'(init) : acc) + AW'($signed(fm[W-1:0]));
  assign fin_in = (ctl.cmd == CMD_INV) ? -NW'(sum) : NW'(sum);
  assign fin    = sat_n(fin_in);

  always_comb begin
    neg_ov = 1'b0;
    for (int i = 0; i < 16; i++) begin
      negs[i] = sat_n(-NW'(cur[i]));
      neg_ov  = neg_ov | negs[i][W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        cur[i] <= (i % 5 == 0) ? ONE : '0;
        opm[i] <= '0;
      end
    end else if (ctl.exec) begin
      case (ctl.cmd)
        CMD_WR_CUR: cur[idx_q] <= sval;
        CMD_WR_OPD: opm[idx_q] <= sval;
        CMD_NEG: begin
          for (int i = 0; i < 16; i++) cur[i] <= negs[i][W-1:0];
        end
        CMD_IDENT: begin
          for (int i = 0; i < 16; i++) cur[i] <= (i % 5 == 0) ? ONE : '0;
        end
        CMD_TRANSP: begin
          for (int r = 0; r < 4; r++)
            for (int j = 0; j < 4; j++) cur[r + 4 * j] <= cur[j + 4 * r];
        end
        default: ;
      endcase
    end else if (ctl.acc_en && ctl.last && ctl.cmd == CMD_SCALE) begin
      cur[ctl.o] <= fin[W-1:0];
    end else if (ctl.commit) begin
      if (ctl.cmd == CMD_MUL) begin
        for (int i = 0; i < 16; i++) cur[i] <= tmp[i];
      end else begin
        for (int r = 0; r < 3; r++) begin
          for (int j = 0; j < 3; j++) cur[r + 4 * j] <= cur[j + 4 * r];
          cur[12 + r]    <= tmp[12 + r];
          cur[3 + 4 * r] <= '0;
        end
        cur[15] <= ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      idx_q <= elem_index;
      sval  <= sv[W-1:0];
      pvec[0] <= sx[W-1:0];
      pvec[1] <= sy[W-1:0];
      pvec[2] <= sz[W-1:0];
      for (int i = 0; i < 3; i++) begin
        tvec[i] <= cur[12 + i];
        res[i]  <= '0;
      end
      rd <= '0;
      case (ctl.cmd) inside
        CMD_WR_CUR, CMD_WR_OPD, CMD_SCALE: flag <= sv[W];
        CMD_XFORM: flag <= sx[W] | sy[W] | sz[W];
        default: flag <= 1'b0;
      endcase
    end
    if (ctl.exec && ctl.cmd == CMD_READ) rd <= a_op;
    if (ctl.exec && ctl.cmd == CMD_NEG) flag <= neg_ov;
    if (ctl.mul_en) prod <= a_op * b_op;
    if (ctl.acc_en) begin
      acc <= sum;
      flag <= flag | fm[W] | (ctl.last & fin[W]);
      if (ctl.last) begin
        case (ctl.cmd)
          CMD_XFORM: res[ctl.o[1:0]] <= fin[W-1:0];
          CMD_MUL: tmp[ctl.o] <= fin[W-1:0];
          CMD_INV: tmp[{2'b11, ctl.o[1:0]}] <= fin[W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_x      <= to32(res[0]);
      out_y      <= to32(res[1]);
      out_z      <= to32(res[2]);
      read_value <= to32(rd);
      status     <= flag;
    end
  end

endmodule

[src/matrix4_transform_engine_unit.sv]
// Top level of the 4x4 column-major fixed-point matrix transform engine.
// Joins mte_ctrl and mte_datapath to the mte_in_if and mte_out_if channels.
//
// Each command item returns exactly one result item. Writes, reads, negate,
// identity and transpose pass through the execute state. Products run through
// one shared multiplier, each term passing through a multiply state and an
// accumulate state: transform has 9 terms, scale 16, inverse 9 and matrix
// multiply 64. One item is worked on at a time; the result register lets
// the next item be accepted while a result waits to be taken.
module matrix4_transform_engine_unit
  import mte_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input logic clk,
  input logic rst,
  mte_in_if.sink    req,
  mte_out_if.source rsp
);

  ctl_t ctl;
  logic out_free;

  mte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_cmd   (req.command),
    .in_ready (req.ready),
    .out_free (out_free),
    .ctl      (ctl)
  );

  mte_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .elem_index (req.elem_index),
    .value      (req.value),
    .px         (req.px),
    .py         (req.py),
    .pz         (req.pz),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_free   (out_free),
    .out_x      (rsp.out_x),
    .out_y      (rsp.out_y),
    .out_z      (rsp.out_z),
    .read_value (rsp.read_value),
    .status     (rsp.status)
  );

`ifndef ASSERT_OFF
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("item accepted while another is in progress");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(!req.ready))
    else $error("result raised without an item in progress");

  a_capture_idle_only: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |-> !ctl.mul_en && !ctl.acc_en && !ctl.finish)
    else $error("capture overlaps datapath work");
`endif

endmodule
